// ===== hdl/reservation_station_table_top_defines.svh =====
// Assertion macros shared by the reservation station table RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef RESERVATION_STATION_TABLE_TOP_DEFINES_SVH
`define RESERVATION_STATION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define RSTBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is asserted
`define RSTBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rstbl_pkg.sv =====
// Types and constants for the reservation station table.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package rstbl_pkg;

  localparam int SLOT_W     = 6;   // slot index field width
  localparam int PORT_PLD_W = 32;  // payload width on the ports
  localparam int CFG_W      = 7;   // entries_in_use register width
  localparam int WIDE_W     = 64;  // staging width for payload resizing
  localparam int GRP_SIZE   = 8;   // slots per first-level search group
  localparam int GRP_W      = 3;   // local index width within a group

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_SET_FREE  = 3'd1,
    OP_SET_SCHED = 3'd2,
    OP_SET_READY = 3'd3,
    OP_SET_WAIT  = 3'd4,
    OP_FLUSH     = 3'd5,
    OP_QUERY     = 3'd6
  } op_e;

  // Flag update command from the control to the flag array
  typedef struct packed {
    logic              valid;
    logic [2:0]        op;
    logic [SLOT_W-1:0] idx;
    logic              wr_empty;
    logic              wr_ready;
  } flag_cmd_t;

  // Search result from the search tree to the control
  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              ready_found;
    logic [SLOT_W-1:0] ready_slot;
    logic              idle;
  } srch_res_t;

endpackage

// ===== hdl/rstbl_if.sv =====
// Channel interfaces for the reservation station table: input, result, config.
// Depends on rstbl_pkg for field widths.
`timescale 1ns / 1ps

interface rstbl_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        opcode;
  logic [rstbl_pkg::SLOT_W-1:0]      slot_index;
  logic [rstbl_pkg::PORT_PLD_W-1:0]  write_payload;
  logic                              write_empty;
  logic                              write_ready;

  modport source (output valid, opcode, slot_index, write_payload, write_empty, write_ready,
                  input ready);
  modport sink   (input valid, opcode, slot_index, write_payload, write_empty, write_ready,
                  output ready);
endinterface

interface rstbl_out_if;
  logic                              valid;
  logic                              ready;
  logic                              free_found;
  logic [rstbl_pkg::SLOT_W-1:0]      free_slot;
  logic                              ready_found;
  logic [rstbl_pkg::SLOT_W-1:0]      ready_slot;
  logic [rstbl_pkg::PORT_PLD_W-1:0]  ready_payload;
  logic                              station_idle;

  modport source (output valid, free_found, free_slot, ready_found, ready_slot, ready_payload,
                  station_idle, input ready);
  modport sink   (input valid, free_found, free_slot, ready_found, ready_slot, ready_payload,
                  station_idle, output ready);
endinterface

interface rstbl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rstbl_pkg::CFG_W-1:0]   entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

// ===== hdl/rstbl_payload_ram.sv =====
// Payload storage: one write port, one read port, registered read data.
// No package dependency.
`timescale 1ns / 1ps

module rstbl_payload_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rstbl_flag_array.sv =====
// Empty and ready flag registers of every slot, with the per-command update.
// Depends on rstbl_pkg (flag_cmd_t, op_e).
`timescale 1ns / 1ps

module rstbl_flag_array #(
  parameter int MAX_SLOTS = 64,
  parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rstbl_pkg::flag_cmd_t  cmd,
  input  logic [CNT_W-1:0]      n_used,
  output logic [MAX_SLOTS-1:0]  empty_o,
  output logic [MAX_SLOTS-1:0]  ready_o
);

  localparam int CMP_W = rstbl_pkg::SLOT_W + 1;

  logic [MAX_SLOTS-1:0] empty_r, empty_nxt;
  logic [MAX_SLOTS-1:0] ready_r, ready_nxt;
  logic                 idx_ok;
  logic                 set_e, set_r;

  assign idx_ok = CMP_W'(cmd.idx) < CMP_W'(n_used);

  // decode the flag pair an addressed command stores
  always_comb begin
    set_e = 1'b0;
    set_r = 1'b0;
    unique case (cmd.op)
      rstbl_pkg::OP_WRITE:     begin set_e = cmd.wr_empty; set_r = cmd.wr_ready; end
      rstbl_pkg::OP_SET_FREE:  begin set_e = 1'b1; set_r = 1'b0; end
      rstbl_pkg::OP_SET_SCHED: begin set_e = 1'b1; set_r = 1'b1; end
      rstbl_pkg::OP_SET_READY: begin set_e = 1'b0; set_r = 1'b1; end
      default:                 begin set_e = 1'b0; set_r = 1'b0; end
    endcase
  end

  // flush scheduled slots in use, or overwrite the addressed slot
  always_comb begin
    empty_nxt = empty_r;
    ready_nxt = ready_r;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (CNT_W'(i) < n_used) begin
        if (cmd.op == rstbl_pkg::OP_FLUSH) begin
          if (empty_r[i] && ready_r[i]) begin
            ready_nxt[i] = 1'b0;
          end
        end else if (cmd.op <= rstbl_pkg::OP_SET_WAIT && idx_ok &&
                     cmd.idx == rstbl_pkg::SLOT_W'(i)) begin
          empty_nxt[i] = set_e;
          ready_nxt[i] = set_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '1;
      ready_r <= '0;
    end else if (cmd.valid) begin
      empty_r <= empty_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign empty_o = empty_r;
  assign ready_o = ready_r;

endmodule

// ===== hdl/rstbl_search.sv =====
// Two-stage registered find-first tree over the slot flags: groups, then groups of groups.
// Depends on rstbl_pkg (srch_res_t, group constants).
`timescale 1ns / 1ps

module rstbl_search #(
  parameter int MAX_SLOTS = 64,
  parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MAX_SLOTS-1:0]  empty_i,
  input  logic [MAX_SLOTS-1:0]  ready_i,
  input  logic [CNT_W-1:0]      n_used,
  output rstbl_pkg::srch_res_t  res_o
);

  localparam int NG    = (MAX_SLOTS + rstbl_pkg::GRP_SIZE - 1) / rstbl_pkg::GRP_SIZE;
  localparam int PAD_W = NG * rstbl_pkg::GRP_SIZE;

  logic [PAD_W-1:0]             free_pad, rdy_pad, busy_pad;
  logic [NG-1:0]                f_hit, r_hit, g_busy;
  logic [rstbl_pkg::GRP_W-1:0]  f_loc [NG];
  logic [rstbl_pkg::GRP_W-1:0]  r_loc [NG];
  logic [NG-1:0]                f_hit_r, r_hit_r, g_busy_r;
  logic [rstbl_pkg::GRP_W-1:0]  f_loc_r [NG];
  logic [rstbl_pkg::GRP_W-1:0]  r_loc_r [NG];
  rstbl_pkg::srch_res_t         res_nxt, res_r;

  // classify the slots in use, pad to whole groups
  always_comb begin
    free_pad = '0;
    rdy_pad  = '0;
    busy_pad = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (CNT_W'(i) < n_used) begin
        free_pad[i] = empty_i[i] & ~ready_i[i];
        rdy_pad[i]  = ~empty_i[i] & ready_i[i];
        busy_pad[i] = ~empty_i[i] | ready_i[i];
      end
    end
  end

  // first level: lowest hit within each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      f_hit[g]  = 1'b0;
      r_hit[g]  = 1'b0;
      g_busy[g] = 1'b0;
      f_loc[g]  = '0;
      r_loc[g]  = '0;
      for (int j = rstbl_pkg::GRP_SIZE - 1; j >= 0; j--) begin
        if (free_pad[g*rstbl_pkg::GRP_SIZE + j]) begin
          f_hit[g] = 1'b1;
          f_loc[g] = rstbl_pkg::GRP_W'(j);
        end
        if (rdy_pad[g*rstbl_pkg::GRP_SIZE + j]) begin
          r_hit[g] = 1'b1;
          r_loc[g] = rstbl_pkg::GRP_W'(j);
        end
        if (busy_pad[g*rstbl_pkg::GRP_SIZE + j]) begin
          g_busy[g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_hit_r  <= '0;
      r_hit_r  <= '0;
      g_busy_r <= '0;
    end else begin
      f_hit_r  <= f_hit;
      r_hit_r  <= r_hit;
      g_busy_r <= g_busy;
    end
  end

  always_ff @(posedge clk) begin
    f_loc_r <= f_loc;
    r_loc_r <= r_loc;
  end

  // second level: lowest group with a hit
  always_comb begin
    res_nxt = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (f_hit_r[g]) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_slot  = rstbl_pkg::SLOT_W'(g * rstbl_pkg::GRP_SIZE) |
                             rstbl_pkg::SLOT_W'(f_loc_r[g]);
      end
      if (r_hit_r[g]) begin
        res_nxt.ready_found = 1'b1;
        res_nxt.ready_slot  = rstbl_pkg::SLOT_W'(g * rstbl_pkg::GRP_SIZE) |
                              rstbl_pkg::SLOT_W'(r_loc_r[g]);
      end
    end
    res_nxt.idle = ~|g_busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== hdl/reservation_station_table_top.sv =====
// Reservation station table top level: control sequencer, config register, result register.
// Depends on rstbl_pkg, rstbl_if, rstbl_payload_ram, rstbl_flag_array, rstbl_search
// and reservation_station_table_top_defines.svh.
//
//   channel | port    | dir | transaction
//   --------+---------+-----+-----------------------------------------------
//   input   | in_ch   | in  | one operation: opcode, slot, write fields
//   result  | out_ch  | out | lowest free slot, lowest ready slot + payload, idle
//   config  | cfg_ch  | in  | entries_in_use write
//
// Each transaction runs through these steps: the accept edge updates the flags and writes
// the payload RAM, the two registered stages of the search tree run, the payload RAM is
// read, and the result register is loaded. A new transaction is taken once the
// previous one has moved into the result register, even while that result still waits.
// Reset sets every flag at once (all slots free); no clearing pass. Payload RAM holds
// no reset value. A stalled result holds the sequencer in its final step.
`timescale 1ns / 1ps
`include "reservation_station_table_top_defines.svh"

module reservation_station_table_top #(
  parameter int MAX_SLOTS     = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  rstbl_in_if.sink      in_ch,
  rstbl_out_if.source   out_ch,
  rstbl_cfg_if.sink     cfg_ch
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = rstbl_pkg::SLOT_W + 1;
  localparam logic [CNT_W-1:0] N_RESET =
    CNT_W'((MAX_SLOTS < 64) ? MAX_SLOTS : 64);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_PICK,
    S_READ,
    S_DONE
  } state_e;

  state_e                           state_r, state_nxt;
  logic [CNT_W-1:0]                 n_r;
  logic                             in_acc;
  logic                             load_out;
  rstbl_pkg::flag_cmd_t             cmd;
  rstbl_pkg::srch_res_t             srch;
  logic [MAX_SLOTS-1:0]             empty_v, ready_v;
  logic                             ram_we;
  logic [rstbl_pkg::WIDE_W-1:0]     wide_in, wide_out;
  logic [PAYLOAD_WIDTH-1:0]         ram_rdata;
  logic                             out_valid_r;
  logic                             free_found_r, ready_found_r, idle_r;
  logic [rstbl_pkg::SLOT_W-1:0]     free_slot_r, ready_slot_r;
  logic [rstbl_pkg::PORT_PLD_W-1:0] ready_payload_r;

  // config register: zero counts as one slot, large values clamp to MAX_SLOTS
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= N_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.entries_in_use == '0) begin
        n_r <= CNT_W'(1);
      end else if (cfg_ch.entries_in_use > rstbl_pkg::CFG_W'(MAX_SLOTS)) begin
        n_r <= CNT_W'(MAX_SLOTS);
      end else begin
        n_r <= CNT_W'(cfg_ch.entries_in_use);
      end
    end
  end

  // accept one transaction at a time; flags update on the accept edge
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cmd.valid    = in_acc;
  assign cmd.op       = in_ch.opcode;
  assign cmd.idx      = in_ch.slot_index;
  assign cmd.wr_empty = in_ch.write_empty;
  assign cmd.wr_ready = in_ch.write_ready;

  rstbl_flag_array #(
    .MAX_SLOTS (MAX_SLOTS),
    .CNT_W     (CNT_W)
  ) u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .n_used  (n_r),
    .empty_o (empty_v),
    .ready_o (ready_v)
  );

  rstbl_search #(
    .MAX_SLOTS (MAX_SLOTS),
    .CNT_W     (CNT_W)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty_i (empty_v),
    .ready_i (ready_v),
    .n_used  (n_r),
    .res_o   (srch)
  );

  // payload write on an in-range write transaction; read the ready slot after the search
  assign ram_we  = in_acc && (in_ch.opcode == rstbl_pkg::OP_WRITE) &&
                   (CMP_W'(in_ch.slot_index) < CMP_W'(n_r));
  assign wide_in = rstbl_pkg::WIDE_W'(in_ch.write_payload);

  rstbl_payload_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (PAYLOAD_WIDTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.slot_index[IDX_W-1:0]),
    .wdata (wide_in[PAYLOAD_WIDTH-1:0]),
    .raddr (srch.ready_slot[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign wide_out = rstbl_pkg::WIDE_W'(ram_rdata);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // sequence the steps of one transaction
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_FIND;
      S_FIND:  state_nxt = S_PICK;
      S_PICK:  state_nxt = S_READ;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      free_found_r    <= 1'b0;
      free_slot_r     <= '0;
      ready_found_r   <= 1'b0;
      ready_slot_r    <= '0;
      ready_payload_r <= '0;
      idle_r          <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r     <= 1'b1;
        free_found_r    <= srch.free_found;
        free_slot_r     <= srch.free_slot;
        ready_found_r   <= srch.ready_found;
        ready_slot_r    <= srch.ready_slot;
        ready_payload_r <= srch.ready_found ? wide_out[rstbl_pkg::PORT_PLD_W-1:0] : '0;
        idle_r          <= srch.idle;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.free_found    = free_found_r;
  assign out_ch.free_slot     = free_slot_r;
  assign out_ch.ready_found   = ready_found_r;
  assign out_ch.ready_slot    = ready_slot_r;
  assign out_ch.ready_payload = ready_payload_r;
  assign out_ch.station_idle  = idle_r;

  // checks on the sequencer and the search result
  `RSTBL_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ch.ready, "second transaction while busy")
  `RSTBL_ASSERT_NOW(a_ready_not_idle, srch.ready_found, !srch.idle, "ready slot in idle station")
  `RSTBL_ASSERT_NOW(a_free_ne_ready, srch.free_found && srch.ready_found, srch.free_slot != srch.ready_slot, "slot both free and ready")
  `RSTBL_ASSERT_NEXT(a_result_loaded, load_out, out_valid_r && state_r == S_IDLE, "result not loaded")

endmodule

// ===== sim/tb_reservation_station_table_top.sv =====
// Self-checking testbench for reservation_station_table_top: directed and random slot traffic.
// Depends on rstbl_pkg, rstbl_if and the block's RTL; predicts every search result in place.
`timescale 1ns / 1ps

module tb_reservation_station_table_top;

  localparam int TBL_SLOTS = 64;
  localparam logic [2:0] OP_UNUSED = 3'd7;   // decodes as a plain query
  localparam int QUIET_CYCLES = 8;           // idle margin after the last result
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [2:0]                       opcode;
    logic [rstbl_pkg::SLOT_W-1:0]     slot_index;
    logic [rstbl_pkg::PORT_PLD_W-1:0] write_payload;
    logic                             write_empty;
    logic                             write_ready;
  } station_op_t;

  typedef struct packed {
    logic                             free_found;
    logic [rstbl_pkg::SLOT_W-1:0]     free_slot;
    logic                             ready_found;
    logic [rstbl_pkg::SLOT_W-1:0]     ready_slot;
    logic [rstbl_pkg::PORT_PLD_W-1:0] ready_payload;
    logic                             station_idle;
  } station_report_t;

  logic clk = 1'b0;
  logic rst_n;

  rstbl_in_if  in_ch ();
  rstbl_out_if out_ch ();
  rstbl_cfg_if cfg_ch ();

  reservation_station_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the slot table and the entries_in_use register
  logic [rstbl_pkg::CFG_W-1:0]      shadow_entries;
  bit                               shadow_empty   [TBL_SLOTS];
  bit                               shadow_ready   [TBL_SLOTS];
  logic [rstbl_pkg::PORT_PLD_W-1:0] shadow_payload [TBL_SLOTS];
  bit                               shadow_written [TBL_SLOTS];

  station_report_t pending_reports[$];
  station_report_t want_report;
  station_report_t seen_report;
  int send_idle_pct = 13;
  int recv_idle_pct = 53;
  int mismatch_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Zero counts as one slot, anything above the table size as the full table
  function automatic int unsigned slots_in_use();
    if (shadow_entries == 0) return 1;
    if (shadow_entries > TBL_SLOTS) return TBL_SLOTS;
    return shadow_entries;
  endfunction

  // Apply one operation to the shadow table and compute the search that follows
  function automatic station_report_t predict_search(input station_op_t op);
    station_report_t rep;
    int unsigned n;
    int unsigned i;
    n = slots_in_use();
    rep = '0;
    rep.station_idle = 1'b1;
    if (op.opcode == rstbl_pkg::OP_FLUSH) begin
      for (i = 0; i < n; i++)
        if (shadow_empty[i] && shadow_ready[i]) shadow_ready[i] = 1'b0;
    end else if (op.opcode <= rstbl_pkg::OP_SET_WAIT && op.slot_index < n) begin
      case (op.opcode)
        rstbl_pkg::OP_WRITE: begin
          shadow_payload[op.slot_index] = op.write_payload;
          shadow_written[op.slot_index] = 1'b1;
          shadow_empty[op.slot_index] = op.write_empty;
          shadow_ready[op.slot_index] = op.write_ready;
        end
        rstbl_pkg::OP_SET_FREE: begin
          shadow_empty[op.slot_index] = 1'b1;
          shadow_ready[op.slot_index] = 1'b0;
        end
        rstbl_pkg::OP_SET_SCHED: begin
          shadow_empty[op.slot_index] = 1'b1;
          shadow_ready[op.slot_index] = 1'b1;
        end
        rstbl_pkg::OP_SET_READY: begin
          shadow_empty[op.slot_index] = 1'b0;
          shadow_ready[op.slot_index] = 1'b1;
        end
        default: begin
          shadow_empty[op.slot_index] = 1'b0;
          shadow_ready[op.slot_index] = 1'b0;
        end
      endcase
    end
    // Priority search from slot zero over the slots in use
    for (i = 0; i < n; i++) begin
      if (!rep.free_found && shadow_empty[i] && !shadow_ready[i]) begin
        rep.free_found = 1'b1;
        rep.free_slot = rstbl_pkg::SLOT_W'(i);
      end
      if (!rep.ready_found && !shadow_empty[i] && shadow_ready[i]) begin
        rep.ready_found = 1'b1;
        rep.ready_slot = rstbl_pkg::SLOT_W'(i);
        rep.ready_payload = shadow_payload[i];
      end
      if (!shadow_empty[i] || shadow_ready[i]) rep.station_idle = 1'b0;
    end
    return rep;
  endfunction

  function automatic station_op_t make_op(input logic [2:0] opcode, input int unsigned idx,
                                          input logic [rstbl_pkg::PORT_PLD_W-1:0] pld,
                                          input bit e, input bit r);
    station_op_t op;
    op.opcode = opcode;
    op.slot_index = rstbl_pkg::SLOT_W'(idx);
    op.write_payload = pld;
    op.write_empty = e;
    op.write_ready = r;
    return op;
  endfunction

  // Random operation, mostly aimed at slots in use; never readies a slot with no payload
  function automatic station_op_t pick_random_op();
    station_op_t op;
    int unsigned n;
    int unsigned roll;
    n = slots_in_use();
    roll = $urandom_range(99);
    if (roll < 34) op.opcode = rstbl_pkg::OP_WRITE;
    else if (roll < 44) op.opcode = rstbl_pkg::OP_SET_FREE;
    else if (roll < 54) op.opcode = rstbl_pkg::OP_SET_SCHED;
    else if (roll < 64) op.opcode = rstbl_pkg::OP_SET_READY;
    else if (roll < 74) op.opcode = rstbl_pkg::OP_SET_WAIT;
    else if (roll < 82) op.opcode = rstbl_pkg::OP_FLUSH;
    else if (roll < 94) op.opcode = rstbl_pkg::OP_QUERY;
    else op.opcode = OP_UNUSED;
    if ($urandom_range(7) == 0)
      op.slot_index = rstbl_pkg::SLOT_W'($urandom_range(TBL_SLOTS - 1));
    else
      op.slot_index = rstbl_pkg::SLOT_W'($urandom_range(n - 1));
    case ($urandom_range(9))
      0: op.write_payload = '0;
      1: op.write_payload = '1;
      default: op.write_payload = $urandom;
    endcase
    op.write_empty = 1'($urandom_range(1));
    op.write_ready = 1'($urandom_range(1));
    if (op.opcode == rstbl_pkg::OP_SET_READY && op.slot_index < n &&
        !shadow_written[op.slot_index])
      op.opcode = rstbl_pkg::OP_WRITE;
    return op;
  endfunction

  function automatic logic [rstbl_pkg::CFG_W-1:0] pick_entries();
    case ($urandom_range(9))
      0: return rstbl_pkg::CFG_W'(0);
      1: return rstbl_pkg::CFG_W'(127);
      2: return rstbl_pkg::CFG_W'(64);
      3: return rstbl_pkg::CFG_W'(1);
      4: return rstbl_pkg::CFG_W'(65 + $urandom_range(62));
      default: return rstbl_pkg::CFG_W'($urandom_range(2, 16));
    endcase
  endfunction

  // Send one transaction, idling at random first; valid stays high on return
  task automatic send_op(input station_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op.opcode;
    in_ch.slot_index <= op.slot_index;
    in_ch.write_payload <= op.write_payload;
    in_ch.write_empty <= op.write_empty;
    in_ch.write_ready <= op.write_ready;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_reports.push_back(predict_search(op));
  endtask

  // Hold off the input until every pending result has come back
  task automatic wait_station_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries(input logic [rstbl_pkg::CFG_W-1:0] value);
    wait_station_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.entries_in_use <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    shadow_entries = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("%0t: %s: expected %p, got %p", $realtime, what, want_report, seen_report);
  endtask

  // Drive the result ready line at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_report.free_found = out_ch.free_found;
      seen_report.free_slot = out_ch.free_slot;
      seen_report.ready_found = out_ch.ready_found;
      seen_report.ready_slot = out_ch.ready_slot;
      seen_report.ready_payload = out_ch.ready_payload;
      seen_report.station_idle = out_ch.station_idle;
      if (pending_reports.size() == 0) begin
        want_report = '0;
        note_mismatch("result with none pending");
      end else begin
        want_report = pending_reports.pop_front();
        if (seen_report.free_found !== want_report.free_found ||
            seen_report.free_slot !== want_report.free_slot ||
            seen_report.ready_found !== want_report.ready_found ||
            seen_report.ready_slot !== want_report.ready_slot ||
            seen_report.ready_payload !== want_report.ready_payload ||
            seen_report.station_idle !== want_report.station_idle)
          note_mismatch("search result mismatch");
      end
    end
  end

  task automatic test_reset_state();
    send_op(make_op(rstbl_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0));
  endtask

  // Every opcode at least once, with payload and index extremes
  task automatic test_each_opcode();
    send_op(make_op(rstbl_pkg::OP_WRITE, 0, 32'h0000_0000, 1'b0, 1'b1));
    send_op(make_op(rstbl_pkg::OP_WRITE, 63, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_op(make_op(rstbl_pkg::OP_WRITE, 1, 32'hA5A5_A5A5, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_WRITE, 2, 32'h5A5A_5A5A, 1'b1, 1'b1));
    send_op(make_op(rstbl_pkg::OP_WRITE, 3, 32'h8000_0001, 1'b1, 1'b0));
    send_op(make_op(rstbl_pkg::OP_SET_SCHED, 0, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_SET_READY, 1, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_SET_WAIT, 63, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_FLUSH, 0, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_SET_FREE, 1, '0, 1'b0, 1'b0));
    send_op(make_op(OP_UNUSED, 0, '1, 1'b1, 1'b1));
    send_op(make_op(rstbl_pkg::OP_QUERY, 63, '0, 1'b0, 1'b0));
  endtask

  // Register extremes, out-of-range indices and flush scope
  task automatic test_entries_limits();
    write_entries(7'd1);
    send_op(make_op(rstbl_pkg::OP_WRITE, 1, 32'h1111_1111, 1'b0, 1'b1));
    send_op(make_op(rstbl_pkg::OP_WRITE, 0, 32'h1234_5678, 1'b0, 1'b1));
    write_entries(7'd0);
    send_op(make_op(rstbl_pkg::OP_SET_SCHED, 0, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_SET_READY, 5, '0, 1'b0, 1'b0));
    write_entries(7'd127);
    send_op(make_op(rstbl_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0));
    write_entries(7'd65);
    send_op(make_op(rstbl_pkg::OP_FLUSH, 0, '0, 1'b0, 1'b0));
    // A scheduled slot beyond the slots in use survives a flush
    write_entries(7'd64);
    send_op(make_op(rstbl_pkg::OP_SET_SCHED, 40, '0, 1'b0, 1'b0));
    write_entries(7'd8);
    send_op(make_op(rstbl_pkg::OP_FLUSH, 0, '0, 1'b0, 1'b0));
    send_op(make_op(rstbl_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0));
    write_entries(7'd64);
    send_op(make_op(rstbl_pkg::OP_QUERY, 0, '0, 1'b0, 1'b0));
  endtask

  // Random traffic with register changes between bursts
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct,
                                     input logic [rstbl_pkg::CFG_W-1:0] first_entries);
    int k;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_entries(first_entries);
    for (k = 0; k < count; k++) begin
      if (k > 0 && k % 115 == 0) write_entries(pick_entries());
      send_op(pick_random_op());
    end
  endtask

  initial begin
    int i;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= rstbl_pkg::OP_QUERY;
    in_ch.slot_index <= '0;
    in_ch.write_payload <= '0;
    in_ch.write_empty <= 1'b0;
    in_ch.write_ready <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.entries_in_use <= 7'd64;
    rst_n <= 1'b0;
    shadow_entries = 7'd64;
    for (i = 0; i < TBL_SLOTS; i++) begin
      shadow_empty[i] = 1'b1;
      shadow_ready[i] = 1'b0;
      shadow_payload[i] = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_each_opcode();
    test_entries_limits();
    test_random_traffic(460, 13, 53, 7'd64);
    test_random_traffic(460, 53, 13, 7'd8);
    test_random_traffic(460, 0, 0, 7'd24);

    wait_station_quiet();
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("reservation_station_table_top regression: pass");
    else
      $display("reservation_station_table_top regression: fail");
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("reservation_station_table_top regression: fail");
    $finish;
  end

endmodule
